[hdl/pixel_colormap_hsv_rgb_defines.svh]
`ifndef PIXEL_COLORMAP_HSV_RGB_DEFINES_SVH
`define PIXEL_COLORMAP_HSV_RGB_DEFINES_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define PCHR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define PCHR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/pchr_pkg.sv]
`timescale 1ns / 1ps

package pchr_pkg;

  // Fixed-point format: FRAC_BITS fraction bits, one integer bit so that 1.0 fits.
  localparam int FRAC_BITS  = 16;
  localparam int FIX_W      = FRAC_BITS + 1;
  localparam int PROD_W     = FIX_W + 8;
  localparam int FULL       = 255;
  localparam int GREY_SCALE = 1000;
  localparam int SECTORS    = 6;
  localparam logic [FIX_W-1:0] ONE = FIX_W'(1) << FRAC_BITS;
  // Saturation s is grey when s * 1000 < ONE, that is s below this limit.
  localparam logic [FIX_W-1:0] GREY_LIMIT =
      FIX_W'(((1 << FRAC_BITS) + GREY_SCALE - 1) / GREY_SCALE);

  // Color mode register codes; the unused code behaves as direct HSV.
  typedef enum logic [1:0] {
    MODE_GRADIENT = 2'd0,
    MODE_HUE      = 2'd1,
    MODE_HSV      = 2'd2
  } mode_e;

  // Hue sectors, each one sixth of the color wheel.
  typedef enum logic [2:0] {
    SEC_RED_YELLOW    = 3'd0,
    SEC_YELLOW_GREEN  = 3'd1,
    SEC_GREEN_CYAN    = 3'd2,
    SEC_CYAN_BLUE     = 3'd3,
    SEC_BLUE_MAGENTA  = 3'd4,
    SEC_MAGENTA_RED   = 3'd5
  } sector_e;

  // Input beat and result beat.
  typedef struct packed {
    logic [16:0] level;
    logic [16:0] saturation;
    logic [16:0] brightness;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_out_t;

  // Front stage result: selected HSV terms and the gradient components.
  typedef struct packed {
    logic             grad;
    logic             grey;
    sector_e          sector;
    logic [FRAC_BITS-1:0] f;
    logic [FIX_W-1:0] s;
    logic [FIX_W-1:0] v;
    logic [FIX_W-1:0] grad_r;
    logic [FIX_W-1:0] grad_g;
    logic [FIX_W-1:0] grad_b;
  } front_t;

  // First product stage: p and the two saturation products.
  typedef struct packed {
    logic             grad;
    logic             grey;
    sector_e          sector;
    logic [FIX_W-1:0] v;
    logic [FIX_W-1:0] p;
    logic [FIX_W-1:0] sf;
    logic [FIX_W-1:0] st;
    logic [FIX_W-1:0] grad_r;
    logic [FIX_W-1:0] grad_g;
    logic [FIX_W-1:0] grad_b;
  } prod_t;

  // Second product stage: all HSV components ready for selection.
  typedef struct packed {
    logic             grad;
    logic             grey;
    sector_e          sector;
    logic [FIX_W-1:0] v;
    logic [FIX_W-1:0] p;
    logic [FIX_W-1:0] q;
    logic [FIX_W-1:0] t;
    logic [FIX_W-1:0] grad_r;
    logic [FIX_W-1:0] grad_g;
    logic [FIX_W-1:0] grad_b;
  } comp_t;

  // Truncating fixed-point product of two values no larger than 1.0.
  function automatic logic [FIX_W-1:0] mul_frac(input logic [FIX_W-1:0] a,
                                                input logic [FIX_W-1:0] b);
    logic [2*FIX_W-1:0] prod;
    prod = (2*FIX_W)'(a) * (2*FIX_W)'(b);
    return prod[FRAC_BITS +: FIX_W];
  endfunction

  // Scale a fraction to a byte, truncating, capped at full scale.
  function automatic logic [7:0] to_byte(input logic [FIX_W-1:0] x);
    logic [PROD_W-1:0]          prod;
    logic [PROD_W-FRAC_BITS-1:0] b;
    prod = PROD_W'(x) * PROD_W'(FULL);
    b    = prod[PROD_W-1:FRAC_BITS];
    return (b > (PROD_W-FRAC_BITS)'(FULL)) ? 8'(FULL) : b[7:0];
  endfunction

endpackage

[hdl/pixel_colormap_hsv_rgb.sv]
`timescale 1ns / 1ps
// Pipeline: an accepted beat passes four register stages (front, first product,
// second product and output) before it is valid on the outputs.
// Throughput: one beat per cycle while the receiver does not stall; the two dependent products of q and t
// (brightness times one minus saturation times fraction) sit in registered stages.
// Reset: clears every stage's valid bit and sets the color mode to gradient;
// pipeline data registers are not reset.
`include "pixel_colormap_hsv_rgb_defines.svh"

module pixel_colormap_hsv_rgb import pchr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pix_valid_i,
  output logic       pix_stall_o,
  input  pix_in_t    pix_i,
  output logic       rgb_valid_o,
  input  logic       rgb_stall_i,
  output pix_out_t   rgb_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i
);

  logic [1:0] mode_q;
  logic       front_valid, front_ready;
  logic       mult_valid, mult_ready;
  logic       pack_ready;
  front_t     front_data;
  comp_t      mult_data;

  // Color mode register; the user must write it only while the block is idle, which the block itself does not enforce.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_GRADIENT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  assign pix_stall_o = !front_ready;

  pchr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pix_valid_i),
    .ready_o (front_ready),
    .pix_i   (pix_i),
    .mode_i  (mode_q),
    .valid_o (front_valid),
    .ready_i (mult_ready),
    .data_o  (front_data)
  );

  pchr_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .ready_o (mult_ready),
    .data_i  (front_data),
    .valid_o (mult_valid),
    .ready_i (pack_ready),
    .data_o  (mult_data)
  );

  pchr_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mult_valid),
    .ready_o (pack_ready),
    .data_i  (mult_data),
    .valid_o (rgb_valid_o),
    .ready_i (!rgb_stall_i),
    .pix_o   (rgb_o)
  );

  // An empty output register means the whole pipeline can move.
  `PCHR_ASSERT_NOW(a_empty_accepts, !rgb_valid_o, !pix_stall_o, "pipeline stalls while empty")
  // An accepted beat lands in the front stage.
  `PCHR_ASSERT_NEXT(a_front_loads, pix_valid_i && !pix_stall_o, front_valid,
                    "accepted beat lost at front stage")
  // A new result comes only from a beat held in the product stages.
  `PCHR_ASSERT_NOW(a_out_source, $rose(rgb_valid_o), $past(mult_valid),
                   "result appeared without a source beat")

endmodule

[hdl/pchr_front.sv]
`timescale 1ns / 1ps

module pchr_front import pchr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  pix_in_t pix_i,
  input  logic [1:0] mode_i,
  output logic    valid_o,
  input  logic    ready_i,
  output front_t  data_o
);

  logic             valid_q;
  front_t           data_q, data_d;
  logic [FIX_W-1:0] lev, sat, bri, h, s, v;
  logic [FIX_W-1:0] grad_r, grad_g, grad_b;
  logic [FIX_W+1:0] h6;
  logic [FIX_W:0]   c;
  logic [FIX_W:0]   gdiff;
  logic [2:0]       sec_raw;

  // Saturate every input to 1.0.
  always_comb begin
    lev = (pix_i.level      > ONE) ? ONE : pix_i.level;
    sat = (pix_i.saturation > ONE) ? ONE : pix_i.saturation;
    bri = (pix_i.brightness > ONE) ? ONE : pix_i.brightness;
  end

  // Pick the HSV terms for the current mode.
  always_comb begin
    h = lev;
    case (mode_i)
      MODE_GRADIENT, MODE_HUE: begin
        s = ONE;
        v = ONE;
      end
      default: begin
        s = sat;
        v = bri;
      end
    endcase
  end

  // Gradient segments: white to yellow, yellow to red, red to black.
  always_comb begin
    c = {1'b0, lev} + {lev, 1'b0};
    grad_r = ONE;
    grad_g = ONE;
    grad_b = '0;
    if (c < (FIX_W+1)'(ONE)) begin
      gdiff = (FIX_W+1)'(ONE) - c;
      grad_b = gdiff[FIX_W-1:0];
    end else if (c < ((FIX_W+1)'(ONE) << 1)) begin
      gdiff = ((FIX_W+1)'(ONE) << 1) - c;
      grad_g = gdiff[FIX_W-1:0];
    end else begin
      gdiff = (FIX_W+1)'(3) * (FIX_W+1)'(ONE) - c;
      grad_r = gdiff[FIX_W-1:0];
      grad_g = '0;
    end
  end

  // Hue times six splits into a sector and a fraction; a full turn wraps to zero.
  always_comb begin
    h6      = {1'b0, h, 1'b0} + {h, 2'b00};
    sec_raw = h6[FRAC_BITS +: 3];
    data_d.grad   = (mode_i == MODE_GRADIENT);
    data_d.grey   = (s < GREY_LIMIT);
    data_d.sector = (sec_raw >= 3'(SECTORS)) ? SEC_RED_YELLOW : sector_e'(sec_raw);
    data_d.f      = h6[FRAC_BITS-1:0];
    data_d.s      = s;
    data_d.v      = v;
    data_d.grad_r = grad_r;
    data_d.grad_g = grad_g;
    data_d.grad_b = grad_b;
  end

  // Stage register.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[hdl/pchr_mult.sv]
`timescale 1ns / 1ps

module pchr_mult import pchr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  front_t data_i,
  output logic   valid_o,
  input  logic   ready_i,
  output comp_t  data_o
);

  logic  prod_valid_q, comp_valid_q;
  logic  prod_ready, comp_ready;
  prod_t prod_q, prod_d;
  comp_t comp_q, comp_d;

  // First products: p, s*f and s*(1-f).
  always_comb begin
    prod_d.grad   = data_i.grad;
    prod_d.grey   = data_i.grey;
    prod_d.sector = data_i.sector;
    prod_d.v      = data_i.v;
    prod_d.p      = mul_frac(data_i.v, ONE - data_i.s);
    prod_d.sf     = mul_frac(data_i.s, {1'b0, data_i.f});
    prod_d.st     = mul_frac(data_i.s, ONE - {1'b0, data_i.f});
    prod_d.grad_r = data_i.grad_r;
    prod_d.grad_g = data_i.grad_g;
    prod_d.grad_b = data_i.grad_b;
  end

  // Second products: q and t scale by brightness.
  always_comb begin
    comp_d.grad   = prod_q.grad;
    comp_d.grey   = prod_q.grey;
    comp_d.sector = prod_q.sector;
    comp_d.v      = prod_q.v;
    comp_d.p      = prod_q.p;
    comp_d.q      = mul_frac(prod_q.v, ONE - prod_q.sf);
    comp_d.t      = mul_frac(prod_q.v, ONE - prod_q.st);
    comp_d.grad_r = prod_q.grad_r;
    comp_d.grad_g = prod_q.grad_g;
    comp_d.grad_b = prod_q.grad_b;
  end

  // Each stage advances when it is empty or the next one takes its beat.
  assign comp_ready = !comp_valid_q || ready_i;
  assign prod_ready = !prod_valid_q || comp_ready;
  assign ready_o    = prod_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      comp_valid_q <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_valid_q <= valid_i;
      end
      if (comp_ready) begin
        comp_valid_q <= prod_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_ready && valid_i) begin
      prod_q <= prod_d;
    end
    if (comp_ready && prod_valid_q) begin
      comp_q <= comp_d;
    end
  end

  assign valid_o = comp_valid_q;
  assign data_o  = comp_q;

endmodule

[hdl/pchr_pack.sv]
`timescale 1ns / 1ps

module pchr_pack import pchr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  comp_t    data_i,
  output logic     valid_o,
  input  logic     ready_i,
  output pix_out_t pix_o
);

  logic             valid_q;
  pix_out_t         pix_q, pix_d;
  logic [FIX_W-1:0] xr, xg, xb;

  // Route the components by mode, grey test and hue sector.
  always_comb begin
    xr = data_i.v;
    xg = data_i.v;
    xb = data_i.v;
    if (data_i.grad) begin
      xr = data_i.grad_r;
      xg = data_i.grad_g;
      xb = data_i.grad_b;
    end else if (!data_i.grey) begin
      case (data_i.sector)
        SEC_RED_YELLOW: begin
          xr = data_i.v; xg = data_i.t; xb = data_i.p;
        end
        SEC_YELLOW_GREEN: begin
          xr = data_i.q; xg = data_i.v; xb = data_i.p;
        end
        SEC_GREEN_CYAN: begin
          xr = data_i.p; xg = data_i.v; xb = data_i.t;
        end
        SEC_CYAN_BLUE: begin
          xr = data_i.p; xg = data_i.q; xb = data_i.v;
        end
        SEC_BLUE_MAGENTA: begin
          xr = data_i.t; xg = data_i.p; xb = data_i.v;
        end
        default: begin
          xr = data_i.v; xg = data_i.p; xb = data_i.q;
        end
      endcase
    end
  end

  // Scale each component to a byte.
  always_comb begin
    pix_d.red   = to_byte(xr);
    pix_d.green = to_byte(xg);
    pix_d.blue  = to_byte(xb);
  end

  // Output register; it holds its beat while the receiver stalls.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pix_q <= pix_d;
    end
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import pchr_pkg::*;

  // The spare register code has no name in the package; it acts as direct HSV.
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [63:0] UNIT = 64'd1 << FRAC_BITS;
  localparam logic [16:0] FIX_ONE = 17'h10000;
  localparam logic [16:0] FIX_MAX = 17'h1FFFF;
  localparam int RANDOM_PIXELS = 1900;
  localparam int DRAIN_CYCLES = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic pix_valid_i = 1'b0;
  logic pix_stall_o;
  pix_in_t pix_i = '0;
  logic rgb_valid_o;
  logic rgb_stall_i = 1'b0;
  pix_out_t rgb_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_data_i = 2'd0;

  // Predictor copy of the color mode register.
  logic [1:0] color_mode = MODE_GRADIENT;
  pix_out_t expected_rgb[$];
  int n_pixels = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_mode_writes = 0;

  pixel_colormap_hsv_rgb dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pix_valid_i),
    .pix_stall_o (pix_stall_o),
    .pix_i       (pix_i),
    .rgb_valid_o (rgb_valid_o),
    .rgb_stall_i (rgb_stall_i),
    .rgb_o       (rgb_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Inputs above 1.0 saturate to 1.0.
  function automatic logic [63:0] clamp_unit(input logic [16:0] x);
    return (x > FIX_ONE) ? UNIT : 64'(x);
  endfunction

  // Truncating scale of a fraction to 0..255.
  function automatic logic [7:0] frac_to_byte(input logic [63:0] x);
    logic [63:0] b;
    b = (x * 64'd255) >> FRAC_BITS;
    return (b > 64'd255) ? 8'd255 : b[7:0];
  endfunction

  function automatic pix_out_t gradient_rgb(input logic [63:0] lev);
    pix_out_t px;
    logic [63:0] c;
    c = lev * 64'd3;
    if (c < UNIT) begin
      px.red = 8'd255;
      px.green = 8'd255;
      px.blue = frac_to_byte(UNIT - c);
    end else if (c < 2 * UNIT) begin
      px.red = 8'd255;
      px.green = frac_to_byte(2 * UNIT - c);
      px.blue = 8'd0;
    end else begin
      px.red = frac_to_byte(3 * UNIT - c);
      px.green = 8'd0;
      px.blue = 8'd0;
    end
    return px;
  endfunction

  // Six-sector HSV conversion; a saturation below 0.001 gives grey.
  function automatic pix_out_t hsv_rgb(input logic [63:0] h, input logic [63:0] s,
                                       input logic [63:0] v);
    pix_out_t px;
    logic [63:0] h6, f, p, q, t, r, g, b;
    sector_e sec;
    if (s * GREY_SCALE < UNIT) begin
      r = v;
      g = v;
      b = v;
    end else begin
      h6 = h * 64'd6;
      sec = sector_e'(3'(((h6 >> FRAC_BITS) % 64'd6)));
      f = h6 & (UNIT - 64'd1);
      p = (v * (UNIT - s)) >> FRAC_BITS;
      q = (v * (UNIT - ((s * f) >> FRAC_BITS))) >> FRAC_BITS;
      t = (v * (UNIT - ((s * (UNIT - f)) >> FRAC_BITS))) >> FRAC_BITS;
      case (sec)
        SEC_RED_YELLOW: begin r = v; g = t; b = p; end
        SEC_YELLOW_GREEN: begin r = q; g = v; b = p; end
        SEC_GREEN_CYAN: begin r = p; g = v; b = t; end
        SEC_CYAN_BLUE: begin r = p; g = q; b = v; end
        SEC_BLUE_MAGENTA: begin r = t; g = p; b = v; end
        default: begin r = v; g = p; b = q; end
      endcase
    end
    px.red = frac_to_byte(r);
    px.green = frac_to_byte(g);
    px.blue = frac_to_byte(b);
    return px;
  endfunction

  function automatic pix_out_t predict_rgb(input pix_in_t px, input logic [1:0] mode);
    case (mode)
      MODE_GRADIENT: return gradient_rgb(clamp_unit(px.level));
      MODE_HUE: return hsv_rgb(clamp_unit(px.level), UNIT, UNIT);
      default: return hsv_rgb(clamp_unit(px.level), clamp_unit(px.saturation),
                              clamp_unit(px.brightness));
    endcase
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    n_errors++;
  endtask

  // Send one pixel beat and record its expected color once it is accepted.
  // Valid stays high afterward so that bursts run back to back.
  task automatic send_pixel(input logic [16:0] lev, input logic [16:0] sat,
                            input logic [16:0] bri);
    pix_in_t px;
    px.level = lev;
    px.saturation = sat;
    px.brightness = bri;
    @(negedge clk_i);
    pix_valid_i <= 1'b1;
    pix_i <= px;
    do @(posedge clk_i); while (pix_stall_o);
    expected_rgb.push_back(predict_rgb(px, color_mode));
    n_pixels++;
  endtask

  // Drop valid and hold off for a number of cycles.
  task automatic pause(input int cycles);
    @(negedge clk_i);
    pix_valid_i <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Wait until every expected color has arrived and the pipeline has drained.
  task automatic wait_idle();
    pause(0);
    while (expected_rgb.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [1:0] code);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= code;
    do @(posedge clk_i); while (!cfg_ready_o);
    color_mode = code;
    n_mode_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Random fraction that favors the ends of the range and values above 1.0.
  function automatic logic [16:0] rand_frac();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return FIX_ONE;
      2: return FIX_ONE - 17'd1;
      3: return 17'($urandom_range(32'h10001, 32'h1FFFF));
      4: return 17'($urandom);
      default: return 17'($urandom_range(0, 32'h10000));
    endcase
  endfunction

  // Saturation sometimes lands around the grey threshold.
  function automatic logic [16:0] rand_sat();
    if ($urandom_range(0, 7) == 0) return 17'($urandom_range(0, 80));
    return rand_frac();
  endfunction

  // Gradient: segment boundaries, full scale and an input above one.
  task automatic test_gradient();
    write_mode(MODE_GRADIENT);
    send_pixel(17'd0, rand_frac(), rand_frac());
    send_pixel(17'd1, rand_frac(), rand_frac());
    send_pixel(17'd21845, FIX_MAX, 17'd0);
    send_pixel(17'd21846, 17'd0, FIX_MAX);
    send_pixel(17'd43690, rand_frac(), rand_frac());
    send_pixel(17'd43691, rand_frac(), rand_frac());
    send_pixel(17'd65535, rand_frac(), rand_frac());
    send_pixel(FIX_ONE, rand_frac(), rand_frac());
    send_pixel(FIX_MAX, FIX_MAX, FIX_MAX);
    pause(3);
  endtask

  // Hue only: sector edges, a hue of exactly one and an input above one.
  task automatic test_hue();
    write_mode(MODE_HUE);
    send_pixel(17'd10922, 17'd0, 17'd0);
    send_pixel(17'd10923, FIX_MAX, FIX_MAX);
    send_pixel(17'd32768, rand_frac(), rand_frac());
    send_pixel(17'd54613, rand_frac(), rand_frac());
    send_pixel(FIX_ONE, rand_frac(), rand_frac());
    send_pixel(FIX_MAX, rand_frac(), rand_frac());
    pause(2);
  endtask

  // Direct HSV: grey threshold, hue wrap, full and zero brightness.
  task automatic test_hsv();
    write_mode(MODE_HSV);
    send_pixel(17'd0, 17'd0, FIX_ONE);
    send_pixel(17'd20000, 17'd65, FIX_ONE);
    send_pixel(17'd20000, 17'd66, FIX_ONE);
    send_pixel(17'd21845, FIX_ONE, FIX_ONE);
    send_pixel(FIX_ONE, FIX_ONE, FIX_MAX);
    send_pixel(17'd43690, FIX_MAX, 17'd0);
    send_pixel(17'd50000, 17'd30000, 17'd40000);
    pause(1);
  endtask

  // The spare mode code must behave as direct HSV.
  task automatic test_spare_mode();
    write_mode(MODE_SPARE);
    send_pixel(17'd60000, 17'd12345, 17'd54321);
    send_pixel(17'd5000, 17'd40, FIX_ONE);
    pause(2);
  endtask

  // Random bursts with random gaps, stepping through every mode in turn.
  task automatic test_random();
    logic [1:0] modes[4];
    int phase, sent, burst, per_phase;
    modes = '{MODE_HSV, MODE_GRADIENT, MODE_SPARE, MODE_HUE};
    per_phase = RANDOM_PIXELS / 12;
    for (phase = 0; phase < 12; phase++) begin
      write_mode(modes[phase % 4]);
      sent = 0;
      while (sent < per_phase) begin
        burst = $urandom_range(1, 24);
        repeat (burst) begin
          send_pixel(rand_frac(), rand_sat(), rand_frac());
          sent++;
        end
        if ($urandom_range(0, 9) == 0) pause($urandom_range(8, 20));
        else pause($urandom_range(0, 4));
      end
    end
  endtask

  // Receiver stall: the style is picked anew at random during the run, from none to heavy.
  int stall_style = 0;
  int stall_cyc = 0;
  always @(negedge clk_i) begin
    stall_cyc <= stall_cyc + 1;
    if (stall_cyc % 256 == 255) stall_style <= $urandom_range(0, 3);
    case (stall_style)
      0: rgb_stall_i <= 1'b0;
      1: rgb_stall_i <= ($urandom_range(0, 9) < 3);
      2: rgb_stall_i <= ($urandom_range(0, 9) < 7);
      default: rgb_stall_i <= (stall_cyc % 5 < 2);
    endcase
  end

  // Compare each accepted color beat with the oldest expectation.
  always @(posedge clk_i) begin : check_rgb
    pix_out_t want;
    if (rst_ni && rgb_valid_o && !rgb_stall_i) begin
      n_results++;
      if (expected_rgb.size() == 0) begin
        report_error($sformatf("unexpected color beat %h", rgb_o));
      end else begin
        want = expected_rgb.pop_front();
        if (rgb_o.red !== want.red)
          report_error($sformatf("red got %0d want %0d", rgb_o.red, want.red));
        if (rgb_o.green !== want.green)
          report_error($sformatf("green got %0d want %0d", rgb_o.green, want.green));
        if (rgb_o.blue !== want.blue)
          report_error($sformatf("blue got %0d want %0d", rgb_o.blue, want.blue));
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_gradient();
    test_hue();
    test_hsv();
    test_spare_mode();
    test_random();
    wait_idle();
    $display("Sent %0d pixels and checked %0d colors over %0d mode writes.",
             n_pixels, n_results, n_mode_writes);
    $display("Covered gradient, hue, direct HSV and the spare mode under random stalls.");
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Timeout with %0d colors still expected.", expected_rgb.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/pchr_pkg.sv
hdl/pchr_front.sv
hdl/pchr_mult.sv
hdl/pchr_pack.sv
hdl/pixel_colormap_hsv_rgb.sv
tb/sv/tb_top.sv
